### design/ipr_pkg.sv
// Shared types, codes and helper functions for the indexed pixel row packer.
package ipr_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam logic [2:0] FMT_RGB565  = 3'd0;
	localparam logic [2:0] FMT_CLUT256 = 3'd1;
	localparam logic [2:0] FMT_GRAY16  = 3'd2;
	localparam logic [2:0] FMT_MONO    = 3'd3;
	localparam logic [2:0] FMT_CLUT32  = 3'd4;

	localparam logic [1:0] REG_FORMAT      = 2'd0;
	localparam logic [1:0] REG_WIDTH       = 2'd1;
	localparam logic [1:0] REG_TRANSP_ON   = 2'd2;
	localparam logic [1:0] REG_TRANSP_IDX  = 2'd3;

	localparam int ADDR_W = 21;
	localparam int DATA_W = 40;

	typedef struct packed {
		logic        operation;
		logic [7:0]  palette_slot;
		logic [15:0] palette_color;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [7:0]  color_index;
		logic        row_end;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] write_address;
		logic [DATA_W-1:0] write_data;
		logic [DATA_W-1:0] bit_mask;
		logic [2:0]        byte_count;
		logic              last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  fmt;
		logic [10:0] width;
		logic        transp_on;
		logic [7:0]  transp_idx;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] field;
		logic [DATA_W-1:0] val;
		logic [DATA_W-1:0] set;
		logic              flush_after;
	} entry_t;

	typedef struct packed {
		logic [DATA_W-1:0] field;
		logic [DATA_W-1:0] val;
	} fv_t;

	function automatic fv_t clut32_bits(input logic [2:0] p, input logic [4:0] c);
		fv_t r;
		int  i;
		int  pos;
		r = '0;
		for (int b = 0; b < 5; b++) begin
			i = 5 * int'(p) + b;
			pos = 8 * (i / 8) + (7 - (i % 8));
			r.field[pos] = 1'b1;
			r.val[pos] = c[4 - b];
		end
		return r;
	endfunction

	function automatic logic [2:0] fmt_bytes(input logic [2:0] fmt);
		logic [2:0] n;
		case (fmt)
			FMT_RGB565: n = 3'd2;
			FMT_CLUT32: n = 3'd5;
			default:    n = 3'd1;
		endcase
		return n;
	endfunction

endpackage

### design/indexed_pixel_row_packer.sv
// Indexed pixel row packer top level: configuration registers, front end, queue, back end.
// Takes one item per cycle while in_stall is low. A pixel is registered at the palette
// read and at the address multiply before the 8-entry queue; the back end merges one queued
// pixel per cycle into the pending write while the output is free. A pixel that flushes
// a pending write and ends its group holds the back end for both writes through the single
// output register. Palette loads take effect for the next pixel and produce no write.
module indexed_pixel_row_packer import ipr_pkg::*; #(
	parameter int MAX_WIDTH     = 1024,
	parameter int PALETTE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item
);
	localparam int QDEPTH = 8;

	logic [2:0]  fmt_q;
	logic [10:0] width_q;
	logic        transp_on_q;
	logic [7:0]  transp_idx_q;
	cfg_t        cfg;

	logic                        push, pop, head_valid;
	entry_t                      push_entry, head;
	logic [$clog2(QDEPTH+1)-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB565;
			width_q <= 11'd1;
			transp_on_q <= 1'b0;
			transp_idx_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORMAT:     fmt_q <= cfg_data[2:0];
				REG_WIDTH:      width_q <= cfg_data;
				REG_TRANSP_ON:  transp_on_q <= cfg_data[0];
				REG_TRANSP_IDX: transp_idx_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.fmt = (fmt_q > FMT_CLUT32) ? FMT_RGB565 : fmt_q;
		cfg.width = width_q;
		cfg.transp_on = transp_on_q;
		cfg.transp_idx = transp_idx_q;
	end

	ipr_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.QDEPTH(QDEPTH)
	) u_front (
		.clk, .arst_n, .cfg,
		.in_valid, .in_stall, .in_item,
		.q_count, .push, .push_entry
	);

	ipr_queue #(.QDEPTH(QDEPTH)) u_queue (
		.clk, .arst_n, .push, .push_entry,
		.pop, .head_valid, .head, .count(q_count)
	);

	ipr_back u_back (
		.clk, .arst_n, .fmt(cfg.fmt),
		.head_valid, .head, .pop,
		.out_valid, .out_stall, .out_item
	);

endmodule

### design/ipr_front.sv
// Front end: accepts items, loads the palette, computes pixel address and bit fields.
module ipr_front import ipr_pkg::*; #(
	parameter int MAX_WIDTH     = 1024,
	parameter int PALETTE_DEPTH = 256,
	parameter int QDEPTH        = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  in_item_t                   in_item,
	input  logic [$clog2(QDEPTH+1)-1:0] q_count,
	output logic                       push,
	output entry_t                     push_entry
);
	localparam int PIW = $clog2(PALETTE_DEPTH);
	localparam int CW  = $clog2(QDEPTH+1);

	logic [15:0] pal_mem [PALETTE_DEPTH];

	logic              v_s1, v_s2;
	logic [2:0]        fmt_s1;
	logic [9:0]        x_s1, y_s1;
	logic [7:0]        idx_s1;
	logic              end_s1, transp_s1, oor_s1;
	logic [ADDR_W-1:0] stride_s1, off_s1;
	logic [15:0]       pal_s1;
	entry_t            entry_s2;

	logic              accept;
	logic [ADDR_W-1:0] w21, stride_c, off_c, m8;
	logic [6:0]        xg;
	logic [15:0]       pal_v;
	logic [3:0]        nib;
	fv_t               fv, c32;
	logic              grp_end, transp;
	entry_t            entry_c;

	assign in_stall = (CW'(q_count) + CW'(v_s1) + CW'(v_s2)) >= CW'(QDEPTH);
	assign accept = in_valid && !in_stall;

	always_comb begin
		w21 = ADDR_W'(cfg.width);
		if (cfg.width == 11'd0) w21 = ADDR_W'(1);
		if (int'(cfg.width) > MAX_WIDTH) w21 = ADDR_W'(MAX_WIDTH);
		m8 = (w21 + ADDR_W'(7)) >> 3;
		xg = in_item.pixel_x[9:3];
		case (cfg.fmt)
			FMT_CLUT256: begin
				stride_c = w21;
				off_c = ADDR_W'(in_item.pixel_x);
			end
			FMT_GRAY16: begin
				stride_c = (w21 + ADDR_W'(1)) >> 1;
				off_c = ADDR_W'(in_item.pixel_x[9:1]);
			end
			FMT_MONO: begin
				stride_c = m8;
				off_c = ADDR_W'(xg);
			end
			FMT_CLUT32: begin
				stride_c = (m8 << 2) + m8;
				off_c = ADDR_W'({xg, 2'b00}) + ADDR_W'(xg);
			end
			default: begin
				stride_c = w21 << 1;
				off_c = ADDR_W'({in_item.pixel_x, 1'b0});
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && in_item.operation == OP_LOAD
				&& {1'b0, in_item.palette_slot} < 9'(PALETTE_DEPTH)) begin
			pal_mem[in_item.palette_slot[PIW-1:0]] <= in_item.palette_color;
		end
		pal_s1 <= pal_mem[in_item.color_index[PIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept && in_item.operation == OP_PIXEL;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		fmt_s1    <= cfg.fmt;
		x_s1      <= in_item.pixel_x;
		y_s1      <= in_item.pixel_y;
		idx_s1    <= in_item.color_index;
		end_s1    <= in_item.row_end;
		transp_s1 <= cfg.transp_on && in_item.color_index == cfg.transp_idx;
		oor_s1    <= {1'b0, in_item.color_index} >= 9'(PALETTE_DEPTH);
		stride_s1 <= stride_c;
		off_s1    <= off_c;
		entry_s2  <= entry_c;
	end

	always_comb begin
		pal_v = oor_s1 ? 16'd0 : pal_s1;
		nib = ~pal_v[4:1];
		c32 = clut32_bits(x_s1[2:0], idx_s1[4:0]);
		fv = '0;
		transp = transp_s1;
		case (fmt_s1)
			FMT_CLUT256: begin
				fv.field = DATA_W'(8'hFF);
				fv.val = DATA_W'(idx_s1);
				grp_end = 1'b1;
			end
			FMT_GRAY16: begin
				fv.field = x_s1[0] ? DATA_W'(8'h0F) : DATA_W'(8'hF0);
				fv.val = x_s1[0] ? DATA_W'(nib) : DATA_W'({nib, 4'h0});
				grp_end = x_s1[0];
				transp = 1'b0;
			end
			FMT_MONO: begin
				fv.field = DATA_W'(8'h80) >> x_s1[2:0];
				fv.val = (idx_s1 != 8'd0) ? fv.field : '0;
				grp_end = x_s1[2:0] == 3'd7;
			end
			FMT_CLUT32: begin
				fv = c32;
				grp_end = x_s1[2:0] == 3'd7;
			end
			default: begin
				fv.field = DATA_W'(16'hFFFF);
				fv.val = DATA_W'(pal_v);
				grp_end = 1'b1;
			end
		endcase
		entry_c.addr = (ADDR_W'(y_s1) * stride_s1) + off_s1;
		entry_c.field = fv.field;
		entry_c.val = transp ? '0 : (fv.val & fv.field);
		entry_c.set = transp ? '0 : fv.field;
		entry_c.flush_after = grp_end || end_s1;
	end

	assign push = v_s2;
	assign push_entry = entry_s2;

endmodule

### design/ipr_queue.sv
// Small queue of classified pixel operations between front and back ends.
module ipr_queue import ipr_pkg::*; #(
	parameter int QDEPTH = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  entry_t                      push_entry,
	input  logic                        pop,
	output logic                        head_valid,
	output entry_t                      head,
	output logic [$clog2(QDEPTH+1)-1:0] count
);
	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH+1);

	entry_t        mem_q [QDEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(QDEPTH-1)) ? '0 : wr_q + PW'(1);
			if (pop) rd_q <= (rd_q == PW'(QDEPTH-1)) ? '0 : rd_q + PW'(1);
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign head_valid = count_q != '0;
	assign head = mem_q[rd_q];
	assign count = count_q;

endmodule

### design/ipr_back.sv
// Back end: merges pixels into the pending write and issues frame-buffer writes.
module ipr_back import ipr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [2:0] fmt,
	input  logic      head_valid,
	input  entry_t    head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	logic              pend_v_q;
	logic [ADDR_W-1:0] pend_addr_q;
	logic [DATA_W-1:0] pend_data_q, pend_mask_q;
	logic              out_v_q;
	out_item_t         out_q;

	logic              out_free, go, flush, second;
	logic [DATA_W-1:0] base_d, base_m, new_d, new_m;

	assign out_free = !out_v_q || !out_stall;
	assign go = head_valid && out_free;
	assign flush = pend_v_q && pend_addr_q != head.addr;
	assign second = flush && head.flush_after;
	assign pop = go && !second;

	always_comb begin
		base_d = (pend_v_q && !flush) ? pend_data_q : '0;
		base_m = (pend_v_q && !flush) ? pend_mask_q : '0;
		new_d = (base_d & ~head.field) | head.val;
		new_m = (base_m & ~head.field) | head.set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_free) out_v_q <= 1'b0;
			if (go) begin
				if (second) begin
					pend_v_q <= 1'b0;
					out_v_q <= 1'b1;
				end else begin
					pend_v_q <= !head.flush_after;
					out_v_q <= flush || head.flush_after;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_q.byte_count <= fmt_bytes(fmt);
			if (flush) begin
				out_q.write_address <= pend_addr_q;
				out_q.write_data <= pend_data_q;
				out_q.bit_mask <= pend_mask_q;
				out_q.last_of_run <= !head.flush_after;
			end else begin
				out_q.write_address <= head.addr;
				out_q.write_data <= new_d;
				out_q.bit_mask <= new_m;
				out_q.last_of_run <= 1'b1;
			end
			if (!second) begin
				pend_addr_q <= head.addr;
				pend_data_q <= new_d;
				pend_mask_q <= new_m;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_item = out_q;

endmodule

### design/ipr_checker.sv
// Port-level checker for the indexed pixel row packer, bound to the top level.
module ipr_checker import ipr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.byte_count == 3'd1 || out_item.byte_count == 3'd2
			|| out_item.byte_count == 3'd5)
		else $error("bad byte count");

	a_data_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.write_data & ~out_item.bit_mask) == '0)
		else $error("data bits set outside the mask");

endmodule

bind indexed_pixel_row_packer ipr_checker u_ipr_checker (
	.clk, .arst_n, .out_valid, .out_stall, .out_item
);

### bench/indexed_pixel_row_packer_tb.sv
// Self-checking bench for the indexed pixel row packer: predicts every frame-buffer write.
module indexed_pixel_row_packer_tb;
	import ipr_pkg::*;

	class write_scoreboard;
		logic [15:0] palette [256];
		logic [39:0] pend_data;
		logic [39:0] pend_mask;
		logic [20:0] pend_addr;
		bit          pend_valid;
		logic [2:0]  fmt;
		logic [10:0] width;
		logic        transp_on;
		logic [7:0]  transp_idx;
		out_item_t   step_writes [$];
		out_item_t   expected_writes [$];
		int          errors;
		int          checked;

		function new();
			foreach (palette[i]) palette[i] = '0;
			pend_data = '0; pend_mask = '0; pend_addr = '0; pend_valid = 0;
			fmt = FMT_RGB565; width = 11'd1; transp_on = 0; transp_idx = '0;
			errors = 0; checked = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [10:0] data);
			case (idx)
				REG_FORMAT:     fmt = data[2:0];
				REG_WIDTH:      width = data;
				REG_TRANSP_ON:  transp_on = data[0];
				REG_TRANSP_IDX: transp_idx = data[7:0];
				default: ;
			endcase
		endfunction

		function void flush_pending(logic [2:0] f);
			out_item_t o;
			o.write_address = pend_addr;
			o.write_data = pend_data;
			o.bit_mask = pend_mask;
			o.byte_count = (f == FMT_RGB565) ? 3'd2 : (f == FMT_CLUT32) ? 3'd5 : 3'd1;
			o.last_of_run = 1'b0;
			step_writes.push_back(o);
			pend_valid = 0; pend_data = '0; pend_mask = '0;
		endfunction

		function void note_input(in_item_t it);
			logic [2:0]  f;
			int          w, stride, off, pos, i;
			logic [39:0] field, val;
			logic [20:0] addr;
			bit          group_end, transparent;
			logic [3:0]  nib;
			logic [2:0]  p;
			logic [4:0]  c;
			if (it.operation == OP_LOAD) begin
				palette[it.palette_slot] = it.palette_color;
				return;
			end
			f = (fmt > FMT_CLUT32) ? FMT_RGB565 : fmt;
			w = (width == 0) ? 1 : (width > 1024) ? 1024 : int'(width);
			transparent = transp_on && (it.color_index == transp_idx);
			field = '0; val = '0;
			case (f)
				FMT_CLUT256: begin
					stride = w; off = int'(it.pixel_x);
					field = 40'hFF; val = 40'(it.color_index);
					group_end = 1;
				end
				FMT_GRAY16: begin
					nib = ~palette[it.color_index][4:1];
					stride = (w + 1) / 2; off = int'(it.pixel_x) / 2;
					if (it.pixel_x[0]) begin
						field = 40'h0F; val = 40'(nib);
					end else begin
						field = 40'hF0; val = 40'({nib, 4'h0});
					end
					group_end = it.pixel_x[0];
					transparent = 0;
				end
				FMT_MONO: begin
					stride = (w + 7) / 8; off = int'(it.pixel_x) / 8;
					field = 40'd1 << (7 - it.pixel_x[2:0]);
					val = (it.color_index != 0) ? field : '0;
					group_end = (it.pixel_x[2:0] == 3'd7);
				end
				FMT_CLUT32: begin
					p = it.pixel_x[2:0]; c = it.color_index[4:0];
					stride = ((w + 7) / 8) * 5; off = (int'(it.pixel_x) / 8) * 5;
					for (int b = 0; b < 5; b++) begin
						i = 5 * int'(p) + b;
						pos = 8 * (i / 8) + (7 - (i % 8));
						field[pos] = 1'b1;
						val[pos] = c[4 - b];
					end
					group_end = (p == 3'd7);
				end
				default: begin
					stride = 2 * w; off = 2 * int'(it.pixel_x);
					field = 40'hFFFF; val = 40'(palette[it.color_index]);
					group_end = 1;
				end
			endcase
			addr = 21'(int'(it.pixel_y) * stride + off);
			if (pend_valid && pend_addr != addr) flush_pending(f);
			if (!pend_valid) begin
				pend_valid = 1; pend_addr = addr; pend_data = '0; pend_mask = '0;
			end
			pend_data &= ~field;
			pend_mask &= ~field;
			if (!transparent) begin
				pend_data |= val & field;
				pend_mask |= field;
			end
			if (group_end || it.row_end) flush_pending(f);
			if (step_writes.size() > 0) step_writes[step_writes.size() - 1].last_of_run = 1'b1;
			foreach (step_writes[k]) expected_writes.push_back(step_writes[k]);
			step_writes.delete();
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			checked++;
			if (expected_writes.size() == 0) begin
				$error("unexpected write at address %h", got.write_address);
				errors++;
				return;
			end
			e = expected_writes.pop_front();
			if (got.write_address !== e.write_address) begin
				$error("write_address exp %h got %h", e.write_address, got.write_address);
				errors++;
			end
			if (got.write_data !== e.write_data) begin
				$error("write_data exp %h got %h", e.write_data, got.write_data);
				errors++;
			end
			if (got.bit_mask !== e.bit_mask) begin
				$error("bit_mask exp %h got %h", e.bit_mask, got.bit_mask);
				errors++;
			end
			if (got.byte_count !== e.byte_count) begin
				$error("byte_count exp %0d got %0d", e.byte_count, got.byte_count);
				errors++;
			end
			if (got.last_of_run !== e.last_of_run) begin
				$error("last_of_run exp %0b got %0b", e.last_of_run, got.last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 0;
	out_item_t   out_item;

	write_scoreboard sb = new();
	bit quiet = 0;
	bit hold_req = 0;
	int sent = 0;

	indexed_pixel_row_packer DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : receiver
		int g;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				g = 400;
				hold_req = 0;
			end else begin
				g = quiet ? 0 : $urandom_range(0, 14);
			end
			if (g > 0) begin
				out_stall <= 1;
				repeat (g) @(negedge clk);
				out_stall <= 0;
			end
			do @(posedge clk); while (!out_valid);
			sb.check_result(out_item);
			@(negedge clk);
		end
	end

	task automatic send(in_item_t it);
		int g;
		g = quiet ? 0 : $urandom_range(0, 14);
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 0;
		while (sb.expected_writes.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [10:0] data);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= data;
		@(negedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, data);
	endtask

	function automatic in_item_t pixel(int x, int y, int idx, bit re);
		in_item_t it;
		it.operation = OP_PIXEL;
		it.palette_slot = 8'($urandom);
		it.palette_color = 16'($urandom);
		it.pixel_x = 10'(x);
		it.pixel_y = 10'(y);
		it.color_index = 8'(idx);
		it.row_end = re;
		return it;
	endfunction

	function automatic in_item_t load(int slot, int color);
		in_item_t it;
		it = pixel($urandom, $urandom, $urandom, 1'($urandom));
		it.operation = OP_LOAD;
		it.palette_slot = 8'(slot);
		it.palette_color = 16'(color);
		return it;
	endfunction

	function automatic int pick_index();
		return ($urandom_range(0, 4) == 0) ? int'(sb.transp_idx) : $urandom_range(0, 255);
	endfunction

	task automatic random_traffic(int n);
		int k, x, y, len, r;
		k = 0;
		while (k < n) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				send(load($urandom_range(0, 255), $urandom));
				k++;
			end else if (r == 1) begin
				send(pixel($urandom_range(0, 1023), $urandom_range(0, 1023), pick_index(),
					1'($urandom_range(0, 1))));
				k++;
			end else begin
				x = $urandom_range(0, 1000);
				y = $urandom_range(0, 1023);
				len = $urandom_range(1, 20);
				if (len > n - k) len = n - k;
				for (int j = 0; j < len && x + j < 1024; j++) begin
					send(pixel(x + j, y, pick_index(),
						(j == len - 1 || x + j == 1023) && $urandom_range(0, 3) != 0));
					k++;
				end
			end
		end
	endtask

	typedef struct {
		int fmt;
		int width;
		int ton;
		int tidx;
	} setting_t;

	initial begin : stimulus
		setting_t plan [12];
		plan = '{
			'{FMT_RGB565, 1, 0, 0}, '{FMT_CLUT256, 1024, 1, 255}, '{FMT_GRAY16, 640, 1, 0},
			'{FMT_MONO, 37, 1, 0}, '{FMT_CLUT32, 1023, 1, 5}, '{FMT_MONO, 0, 0, 0},
			'{FMT_CLUT32, 2047, 1, 31}, '{5, 100, 1, 7}, '{7, 8, 0, 200},
			'{FMT_GRAY16, 1, 1, 3}, '{FMT_CLUT256, 333, 0, 0}, '{FMT_RGB565, 1024, 1, 9}
		};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		quiet = 1;
		for (int s = 0; s < 256; s++) send(load(s, $urandom));
		send(load(0, 16'h0000));
		send(load(255, 16'hFFFF));
		wait_idle();
		quiet = 0;

		write_reg(REG_FORMAT, 11'(FMT_RGB565));
		write_reg(REG_WIDTH, 11'd1024);
		write_reg(REG_TRANSP_ON, 11'd1);
		write_reg(REG_TRANSP_IDX, 11'd255);
		send(pixel(0, 0, 0, 0));
		send(pixel(1023, 1023, 255, 1));
		send(pixel(1023, 0, 0, 1));
		send(pixel(0, 1023, 128, 0));
		send(load(7, 16'h1234));
		send(pixel(5, 5, 7, 1));
		wait_idle();
		write_reg(REG_FORMAT, 11'(FMT_CLUT32));
		for (int j = 0; j < 8; j++) send(pixel(j, 2, (j == 3) ? 255 : 31 + j * 32, 0));
		send(pixel(3, 4, 255, 0));
		send(pixel(9, 4, 17, 0));
		send(pixel(10, 4, 0, 1));
		wait_idle();
		write_reg(REG_FORMAT, 11'(FMT_GRAY16));
		send(pixel(4, 1, 255, 0));
		wait_idle();
		write_reg(REG_FORMAT, 11'(FMT_MONO));
		send(pixel(6, 1, 1, 1));
		wait_idle();

		foreach (plan[p]) begin
			write_reg(REG_FORMAT, 11'(plan[p].fmt));
			write_reg(REG_WIDTH, 11'(plan[p].width));
			write_reg(REG_TRANSP_ON, 11'(plan[p].ton));
			write_reg(REG_TRANSP_IDX, 11'(plan[p].tidx));
			if (p == 4) quiet = 1;
			random_traffic(65);
			quiet = 0;
			if (p == 2) begin
				in_valid <= 0;
				hold_req = 1;
				repeat (2) @(negedge clk);
				quiet = 1;
				random_traffic(60);
				quiet = 0;
			end
			random_traffic(65);
			if (p == 6) begin
				wait_idle();
				random_traffic(20);
			end
			wait_idle();
		end

		wait_idle();
		$display("Covered %0d input transfers and %0d checked writes", sent, sb.checked);
		$display("across all five formats, width extremes and transparency settings.");
		if (sb.errors == 0 && sb.expected_writes.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

### filelist.f
design/ipr_pkg.sv
design/ipr_front.sv
design/ipr_queue.sv
design/ipr_back.sv
design/indexed_pixel_row_packer.sv
design/ipr_checker.sv
bench/indexed_pixel_row_packer_tb.sv
